// File: rtl/rxld_pkg.sv
// rxld_pkg: shared types, constants and helpers for the rotate/xor/lcg digest
// no dependencies
package rxld_pkg;

	localparam int NumWords = 8;
	localparam int WordIdxW = 3;
	localparam int ByteCntW = 5;
	localparam int QueueDepth = 4;
	localparam int QueueAw = 2;

	localparam logic [4:0] ROT_MODE0 = 5'd5;
	localparam logic [4:0] ROT_MODE1 = 5'd7;
	localparam logic [31:0] MUL_MODE0 = 32'd1103515245;
	localparam logic [31:0] INC_MODE0 = 32'd12345;
	localparam logic [31:0] MUL_MODE1 = 32'd69069;
	localparam logic [31:0] INC_MODE1 = 32'd1;

	localparam logic [WordIdxW-1:0] LAST_WORD_MODE0 = 3'd7;
	localparam logic [WordIdxW-1:0] LAST_WORD_MODE1 = 3'd3;
	localparam logic [ByteCntW-1:0] LAST_BYTE_MODE0 = 5'd31;
	localparam logic [ByteCntW-1:0] LAST_BYTE_MODE1 = 5'd15;

	localparam logic KIND_ABSORB = 1'b0;
	localparam logic KIND_FINISH = 1'b1;
	localparam logic MODE_WIDE = 1'b0;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] digest_byte;
		logic       last_byte;
	} result_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} q_link_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ABSORB,
		ST_EMIT
	} state_t;

	function automatic logic [31:0] init_word(input logic mode, input logic [WordIdxW-1:0] idx);
		logic [31:0] w;
		w = 32'h0;
		if (mode == MODE_WIDE) begin
			case (idx)
				3'd0: w = 32'h6a09e667;
				3'd1: w = 32'hbb67ae85;
				3'd2: w = 32'h3c6ef372;
				3'd3: w = 32'ha54ff53a;
				3'd4: w = 32'h510e527f;
				3'd5: w = 32'h9b05688c;
				3'd6: w = 32'h1f83d9ab;
				3'd7: w = 32'h5be0cd19;
				default: w = 32'h0;
			endcase
		end else begin
			case (idx)
				3'd0: w = 32'h67452301;
				3'd1: w = 32'hefcdab89;
				3'd2: w = 32'h98badcfe;
				3'd3: w = 32'h10325476;
				default: w = 32'h0;
			endcase
		end
		return w;
	endfunction

endpackage

// File: rtl/rxld_front.sv
// rxld_front: input side, accepts transactions into a short queue for the back end
// depends on rxld_pkg
module rxld_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  rxld_pkg::item_t item,
	output rxld_pkg::q_link_t q_out,
	input  logic            q_pop
);
	import rxld_pkg::*;

	item_t              mem_q [QueueDepth];
	logic [QueueAw-1:0] wr_ptr_q;
	logic [QueueAw-1:0] rd_ptr_q;
	logic [QueueAw:0]   count_q;
	logic               push;
	logic               pop;

	assign item_stall = (count_q == (QueueAw+1)'(QueueDepth));
	assign push = item_valid && !item_stall;
	assign pop = q_pop && (count_q != '0);

	assign q_out.valid = (count_q != '0);
	assign q_out.item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/rxld_back.sv
// rxld_back: executes queued transactions, holds the hash words and drives results
// depends on rxld_pkg
module rxld_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              mode_we,
	input  logic              mode_wdata,
	input  rxld_pkg::q_link_t q_in,
	output logic              q_pop,
	output logic              result_valid,
	input  logic              result_stall,
	output rxld_pkg::result_t result
);
	import rxld_pkg::*;

	state_t              state_q;
	state_t              state_d;
	logic                mode_q;
	logic [31:0]         words_q [NumWords];
	logic [31:0]         v_q;
	logic [ByteCntW-1:0] cnt_q;
	logic                out_valid_q;
	result_t             out_q;

	logic [WordIdxW-1:0] widx;
	logic [31:0]         cur_word;
	logic [31:0]         rot_word;
	logic [31:0]         v_next;
	logic [WordIdxW-1:0] last_word;
	logic [ByteCntW-1:0] last_byte;
	logic [4:0]          sh;
	logic                out_free;
	logic                word_wr;
	logic                emit_ld;
	logic                reload;

	assign last_word = (mode_q == MODE_WIDE) ? LAST_WORD_MODE0 : LAST_WORD_MODE1;
	assign last_byte = (mode_q == MODE_WIDE) ? LAST_BYTE_MODE0 : LAST_BYTE_MODE1;
	assign widx = (state_q == ST_EMIT) ? cnt_q[4:2] : cnt_q[2:0];
	assign cur_word = words_q[widx];
	assign rot_word = (mode_q == MODE_WIDE) ?
		((cur_word << ROT_MODE0) | (cur_word >> (6'd32 - {1'b0, ROT_MODE0}))) :
		((cur_word << ROT_MODE1) | (cur_word >> (6'd32 - {1'b0, ROT_MODE1})));
	assign v_next = (mode_q == MODE_WIDE) ? (v_q * MUL_MODE0 + INC_MODE0) :
		(v_q * MUL_MODE1 + INC_MODE1);
	assign sh = (mode_q == MODE_WIDE) ? {~cnt_q[1:0], 3'b000} : {cnt_q[1:0], 3'b000};
	assign out_free = !out_valid_q || !result_stall;

	assign result_valid = out_valid_q;
	assign result = out_q;

	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		word_wr = 1'b0;
		emit_ld = 1'b0;
		reload = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_in.valid) begin
					q_pop = 1'b1;
					state_d = (q_in.item.kind == KIND_FINISH) ? ST_EMIT : ST_ABSORB;
				end
			end
			ST_ABSORB: begin
				word_wr = 1'b1;
				if (cnt_q[2:0] == last_word) begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					emit_ld = 1'b1;
					if (cnt_q == last_byte) begin
						reload = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q <= MODE_WIDE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NumWords; i++) begin
				words_q[i] <= init_word(MODE_WIDE, WordIdxW'(i));
			end
		end else begin
			state_q <= state_d;
			if (mode_we) begin
				mode_q <= mode_wdata;
				for (int i = 0; i < NumWords; i++) begin
					words_q[i] <= init_word(mode_wdata, WordIdxW'(i));
				end
			end else if (reload) begin
				for (int i = 0; i < NumWords; i++) begin
					words_q[i] <= init_word(mode_q, WordIdxW'(i));
				end
			end else if (word_wr) begin
				words_q[widx] <= rot_word ^ v_q;
			end
			if (q_pop) begin
				cnt_q <= '0;
			end else if (word_wr || emit_ld) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (emit_ld) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			v_q <= {24'h0, q_in.item.data_byte};
		end else if (word_wr) begin
			v_q <= v_next;
		end
		if (emit_ld) begin
			out_q.digest_byte <= 8'(cur_word >> sh);
			out_q.last_byte <= (cnt_q == last_byte);
		end
	end

endmodule

// File: rtl/rotate_xor_lcg_digest_top.sv
// rotate_xor_lcg_digest_top: top level of the rotate/xor/lcg toy digest
// depends on rxld_pkg, rxld_front, rxld_back
//
// channels: item (kind, data_byte) in, result (digest_byte, last_byte) out,
// each moved by valid/stall; a transaction completes when valid is high and
// stall is low. mode_we/mode_wdata write the mode register; the user must do
// so only while idle, as the block itself does not enforce it. the front end
// queues up to four items, so the sender is only stalled when the queue is
// full. the back end takes one item at a time from the queue: an absorb item
// updates 8 words in mode 0 and 4 words in mode 1, one word per cycle through
// a single rotate/xor and generator multiply. a finish item gives 32 (mode 0)
// or 16 (mode 1) result transactions, one byte per cycle through the output
// register while the result is not stalled; the first byte goes from the
// queue through the back end state register and then the output register.
// a stalled result holds in the output register and the back end waits;
// the front end keeps taking items until the queue fills.
// reset empties the queue, selects mode 0 and loads its initial words;
// a mode write and the last byte of a digest reload the initial words.
module rotate_xor_lcg_digest_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              mode_we,
	input  logic              mode_wdata,
	input  logic              item_valid,
	output logic              item_stall,
	input  rxld_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output rxld_pkg::result_t result
);
	import rxld_pkg::*;

	q_link_t q_link;
	logic    q_pop;

	rxld_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_out      (q_link),
		.q_pop      (q_pop)
	);

	rxld_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.mode_we      (mode_we),
		.mode_wdata   (mode_wdata),
		.q_in         (q_link),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// File: sim/rxld_digest_checker.sv
// rxld_digest_checker: predicts and checks the digest bytes of rotate_xor_lcg_digest_top
// watches the mode write, item and result channels; depends on rxld_pkg
`timescale 1ns / 100ps

module rxld_digest_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              mode_we,
	input  logic              mode_wdata,
	input  logic              item_valid,
	input  logic              item_stall,
	input  rxld_pkg::item_t   item,
	input  logic              result_valid,
	input  logic              result_stall,
	input  rxld_pkg::result_t result,
	output int                mismatches,
	output int                outstanding
);
	import rxld_pkg::*;

	localparam logic [255:0] WIDE_SEED = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};
	localparam logic [127:0] NARROW_SEED = {
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
	};
	localparam logic [31:0] WIDE_MUL = 32'd1103515245;
	localparam logic [31:0] WIDE_INC = 32'd12345;
	localparam logic [31:0] NARROW_MUL = 32'd69069;
	localparam logic [31:0] NARROW_INC = 32'd1;

	logic [31:0] digest_words [8];
	logic        cur_mode;
	result_t     expected_bytes [$];

	function automatic void reload_words();
		for (int i = 0; i < 8; i++) begin
			if (cur_mode == MODE_WIDE) begin
				digest_words[i] = WIDE_SEED[255 - 32 * i -: 32];
			end else if (i < 4) begin
				digest_words[i] = NARROW_SEED[127 - 32 * i -: 32];
			end else begin
				digest_words[i] = 32'h0;
			end
		end
	endfunction

	function automatic void note_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: digest mismatch: %s", $realtime, what);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] lcg;
		logic [31:0] mul;
		logic [31:0] inc;
		int          n_words;
		int          rot;
		int          shift;
		result_t     want;

		if (!arst_n) begin
			cur_mode = MODE_WIDE;
			reload_words();
			expected_bytes.delete();
			mismatches = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_bytes.size() == 0) begin
					note_mismatch($sformatf("byte %02h last %0b with no transaction expected",
						result.digest_byte, result.last_byte));
				end else begin
					want = expected_bytes.pop_front();
					if (result.digest_byte !== want.digest_byte ||
					    result.last_byte !== want.last_byte) begin
						note_mismatch($sformatf("expected byte %02h last %0b, got byte %02h last %0b",
							want.digest_byte, want.last_byte,
							result.digest_byte, result.last_byte));
					end
				end
			end

			if (mode_we) begin
				cur_mode = mode_wdata;
				reload_words();
			end

			if (item_valid && !item_stall) begin
				n_words = (cur_mode == MODE_WIDE) ? 8 : 4;
				if (item.kind == KIND_FINISH) begin
					for (int i = 0; i < n_words; i++) begin
						for (int k = 0; k < 4; k++) begin
							shift = (cur_mode == MODE_WIDE) ? 24 - 8 * k : 8 * k;
							want.digest_byte = 8'(digest_words[i] >> shift);
							want.last_byte = (i * 4 + k == n_words * 4 - 1);
							expected_bytes.push_back(want);
						end
					end
					reload_words();
				end else begin
					rot = (cur_mode == MODE_WIDE) ? 5 : 7;
					mul = (cur_mode == MODE_WIDE) ? WIDE_MUL : NARROW_MUL;
					inc = (cur_mode == MODE_WIDE) ? WIDE_INC : NARROW_INC;
					lcg = {24'h0, item.data_byte};
					for (int j = 0; j < n_words; j++) begin
						digest_words[j] = ((digest_words[j] << rot) |
							(digest_words[j] >> (32 - rot))) ^ lcg;
						lcg = lcg * mul + inc;
					end
				end
			end
		end
		outstanding = expected_bytes.size();
	end

endmodule

// File: sim/tb_top.sv
// tb_top: stimulus and verdict for rotate_xor_lcg_digest_top
// depends on rxld_pkg, rotate_xor_lcg_digest_top and rxld_digest_checker
`timescale 1ns / 100ps

module tb_top;
	import rxld_pkg::*;

	localparam int HoldCycles = 400;
	localparam int SettleCycles = 64;
	localparam int WatchdogLimit = 4000;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    mode_we = 1'b0;
	logic    mode_wdata = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	int      mismatches;
	int      outstanding;
	int      quiet_cycles = 0;
	int      hold_left = 0;
	bit      calm = 1'b0;
	bit      hold_req = 1'b0;

	rotate_xor_lcg_digest_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.mode_we      (mode_we),
		.mode_wdata   (mode_wdata),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	rxld_digest_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.mode_we      (mode_we),
		.mode_wdata   (mode_wdata),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HoldCycles;
				result_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left--;
			end else begin
				result_stall <= !calm && ($urandom_range(99) < 22);
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		while (quiet_cycles < WatchdogLimit) @(posedge clk);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic send_item(input logic kind, input logic [7:0] data_byte);
		item_t next;
		next.kind = kind;
		next.data_byte = data_byte;
		if (!calm && $urandom_range(99) < 22) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= next;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_mode(input logic value);
		mode_we <= 1'b1;
		mode_wdata <= value;
		@(posedge clk);
		mode_we <= 1'b0;
	endtask

	task automatic random_messages(input int n_items);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
			repeat (len) send_item(KIND_ABSORB, 8'($urandom_range(255)));
			send_item(KIND_FINISH, 8'($urandom_range(255)));
			sent += len + 1;
		end
	endtask

	initial begin
		int phase;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// wide mode straight from reset, empty message first
		send_item(KIND_FINISH, 8'h00);
		send_item(KIND_ABSORB, 8'h00);
		send_item(KIND_ABSORB, 8'hff);
		send_item(KIND_ABSORB, 8'ha5);
		send_item(KIND_ABSORB, 8'h5a);
		send_item(KIND_FINISH, 8'hff);
		drain();

		write_mode(~MODE_WIDE);
		send_item(KIND_FINISH, 8'h3c);
		send_item(KIND_ABSORB, 8'h01);
		send_item(KIND_ABSORB, 8'h80);
		send_item(KIND_ABSORB, 8'hff);
		send_item(KIND_FINISH, 8'h00);

		// rewrite of the same mode drops the absorbed byte
		send_item(KIND_ABSORB, 8'h77);
		drain();
		write_mode(~MODE_WIDE);
		send_item(KIND_FINISH, 8'h00);

		send_item(KIND_ABSORB, 8'h42);
		drain();
		write_mode(MODE_WIDE);
		send_item(KIND_ABSORB, 8'h00);
		send_item(KIND_FINISH, 8'h00);

		for (phase = 0; phase < 6; phase++) begin
			drain();
			if (phase < 4) begin
				write_mode((phase == 1 || phase == 2) ? ~MODE_WIDE : MODE_WIDE);
			end else begin
				write_mode(1'($urandom_range(1)));
			end
			calm = (phase == 3);
			if (phase == 2) begin
				hold_req = 1'b1;
			end
			if (phase == 4) begin
				random_messages(25);
				drain();
				random_messages(25);
			end else begin
				random_messages(50);
			end
		end
		calm = 1'b0;
		drain();

		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
